/* rtl/srte_pkg.sv */
// shared types, constants and codes for the stride run trace encoder
`timescale 1ns / 1ps

package srte_pkg;

   // address arithmetic width, 16 to 64
   localparam int ADDR_BITS = 64;
   // run count width, 8 to 64; counts stop at the smaller of this and 32 bits
   localparam int COUNT_BITS = 32;
   localparam int CNT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;

   // port field widths
   localparam int ADDR_FIELD_W = 64;
   localparam int SIZE_W = 8;
   localparam int COUNT_FIELD_W = 32;

   // decoupling queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [SIZE_W-1:0] size_type;

   localparam count_type COUNT_CAP = '1;

   // operation codes carried through the queue
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic kind;
      addr_type addr;
      size_type size;
   } op_type;

   typedef struct packed {
      logic [ADDR_FIELD_W-1:0] start_address;
      logic [ADDR_FIELD_W-1:0] base_delta;
      logic [ADDR_FIELD_W-1:0] stride;
      size_type access_size;
      logic [COUNT_FIELD_W-1:0] repeat_count;
      logic first_of_trace;
   } rsp_type;

   // sign-extend an address-wide value to the port width
   function automatic logic [ADDR_FIELD_W-1:0] widen(input addr_type v);
      widen = ADDR_FIELD_W'(signed'(v));
   endfunction

endpackage

/* rtl/srte_front.sv */
// front end: transfer acceptance and classification of incoming items
`timescale 1ns / 1ps

module srte_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [63:0]                   req_access_address,
   input  logic [7:0]                    req_access_size,
   input  logic                          queue_full,
   output logic                          push,
   output srte_pkg::op_type              push_op
);
   import srte_pkg::*;

   logic is_flush;
   logic is_void;

   // classify: flush, real access, or zero-size access that is dropped
   assign is_flush = (req_cmd == OP_FLUSH);
   assign is_void = !is_flush && (req_access_size == '0);

   // stall only on a full queue, so stall never depends on valid
   assign req_stall = queue_full;
   assign push = req_valid && !queue_full && !is_void;

   // only the low address bits take part in the arithmetic
   assign push_op.kind = is_flush ? OP_FLUSH : OP_ACCESS;
   assign push_op.addr = ADDR_BITS'(req_access_address);
   assign push_op.size = SIZE_W'(req_access_size);

endmodule

/* rtl/srte_queue.sv */
// short register queue decoupling the front end from the run engine
`timescale 1ns / 1ps

module srte_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  srte_pkg::op_type     push_op,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output srte_pkg::op_type     head_op
);
   import srte_pkg::*;

   op_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

endmodule

/* rtl/srte_back.sv */
// run engine: open run state, stride detection and result register
`timescale 1ns / 1ps

module srte_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  srte_pkg::op_type     in_op,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output srte_pkg::rsp_type    rsp_data
);
   import srte_pkg::*;

   // open run state
   logic       run_open_ff, run_open_in;
   addr_type   open_base_ff, open_base_in;
   addr_type   open_stride_ff, open_stride_in;
   size_type   open_size_ff, open_size_in;
   count_type  open_count_ff, open_count_in;
   addr_type   predicted_ff, predicted_in;
   addr_type   previous_base_ff, previous_base_in;
   logic       any_emitted_ff, any_emitted_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       is_flush;
   logic       may_extend;
   logic       second_access;
   logic       hit;
   logic       emit;
   logic       out_ready;
   addr_type   first_stride;
   addr_type   second_predict;
   addr_type   next_predict;
   addr_type   delta;

   // classification of the head item against the open run
   assign is_flush = (in_op.kind == OP_FLUSH);
   assign may_extend = run_open_ff && (in_op.size == open_size_ff)
                       && (open_count_ff != COUNT_CAP);
   assign second_access = may_extend && (open_count_ff == count_type'(1));
   assign hit = may_extend && !second_access && (in_op.addr == predicted_ff);
   assign emit = run_open_ff && (is_flush || (!second_access && !hit));

   // the result slot frees when empty or taken this cycle
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign pop = in_valid && (out_ready || !emit);

   // address arithmetic, each a single wide add
   assign first_stride = in_op.addr - open_base_ff;
   assign second_predict = {in_op.addr[ADDR_BITS-2:0], 1'b0} - open_base_ff;
   assign next_predict = in_op.addr + open_stride_ff;
   assign delta = open_base_ff - previous_base_ff;

   // next state of the open run
   always_comb begin
      run_open_in = run_open_ff;
      open_base_in = open_base_ff;
      open_stride_in = open_stride_ff;
      open_size_in = open_size_ff;
      open_count_in = open_count_ff;
      predicted_in = predicted_ff;
      previous_base_in = previous_base_ff;
      any_emitted_in = any_emitted_ff;
      if (pop) begin
         if (emit) begin
            previous_base_in = open_base_ff;
            any_emitted_in = 1'b1;
            run_open_in = 1'b0;
         end
         priority if (is_flush) begin
            run_open_in = 1'b0;
            open_base_in = '0;
            open_stride_in = '0;
            open_size_in = '0;
            open_count_in = '0;
            predicted_in = '0;
            previous_base_in = '0;
            any_emitted_in = 1'b0;
         end else if (second_access) begin
            open_stride_in = first_stride;
            open_count_in = count_type'(2);
            predicted_in = second_predict;
         end else if (hit) begin
            open_count_in = count_type'(open_count_ff + 1'b1);
            predicted_in = next_predict;
         end else begin
            // a new run opens with this access
            run_open_in = 1'b1;
            open_base_in = in_op.addr;
            open_stride_in = '0;
            open_size_in = in_op.size;
            open_count_in = count_type'(1);
            predicted_in = in_op.addr;
         end
      end
   end

   // result register load and release
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.start_address = ADDR_FIELD_W'(open_base_ff);
         rsp_data_in.base_delta = any_emitted_ff ? widen(delta) : '0;
         rsp_data_in.stride = widen(open_stride_ff);
         rsp_data_in.access_size = open_size_ff;
         rsp_data_in.repeat_count = COUNT_FIELD_W'(open_count_ff);
         rsp_data_in.first_of_trace = !any_emitted_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         open_base_ff <= '0;
         open_stride_ff <= '0;
         open_size_ff <= '0;
         open_count_ff <= '0;
         predicted_ff <= '0;
         previous_base_ff <= '0;
         any_emitted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_open_ff <= run_open_in;
         open_base_ff <= open_base_in;
         open_stride_ff <= open_stride_in;
         open_size_ff <= open_size_in;
         open_count_ff <= open_count_in;
         predicted_ff <= predicted_in;
         previous_base_ff <= previous_base_in;
         any_emitted_ff <= any_emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_open_has_count: assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (open_count_ff != '0))
      else $error("open run with zero count");

   a_result_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.repeat_count != '0)
                       && (rsp_data_ff.access_size != '0))
      else $error("result with empty run");

   a_flush_restarts: assert property (@(posedge clock) disable iff (reset)
      (pop && is_flush) |=> (!any_emitted_ff && !run_open_ff))
      else $error("flush did not restart trace");

   a_first_zero_delta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.first_of_trace) |-> (rsp_data_ff.base_delta == '0))
      else $error("first run of trace with nonzero delta");

endmodule

/* rtl/stride_run_trace_encoder.sv */
// top level of the stride run trace encoder
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    cmd, access_address, access_size
//   rsp      out        rsp_valid/stall    run_start_address, base_delta, run_stride,
//                                          run_access_size, repeat_count, first_of_trace
//
// one item per cycle sustained unless a run-closing item meets a stalled result;
// the run engine decides each item combinationally, one wide add and one address
// compare on the critical path. a closing item is queued, then its result registered.
// synchronous reset clears the queue, the open run and the result register.
// a stalled result holds; items that close no run keep flowing past it, and
// req_stall rises only once the two-entry queue is full.
`timescale 1ns / 1ps

module stride_run_trace_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [63:0]        req_access_address,
   input  logic [7:0]         req_access_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_run_start_address,
   output logic signed [63:0] rsp_base_delta,
   output logic signed [63:0] rsp_run_stride,
   output logic [7:0]         rsp_run_access_size,
   output logic [31:0]        rsp_repeat_count,
   output logic               rsp_first_of_trace
);
   import srte_pkg::*;

   logic       push;
   op_type     push_op;
   logic       pop;
   logic       queue_full;
   logic       queue_not_empty;
   op_type     head_op;
   rsp_type    rsp_data;

   // front end
   srte_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_access_address (req_access_address),
      .req_access_size    (req_access_size),
      .queue_full         (queue_full),
      .push               (push),
      .push_op            (push_op)
   );

   // decoupling queue
   srte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_op   (head_op)
   );

   // run engine
   srte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_not_empty),
      .in_op     (head_op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // result fields
   assign rsp_run_start_address = rsp_data.start_address;
   assign rsp_base_delta = signed'(rsp_data.base_delta);
   assign rsp_run_stride = signed'(rsp_data.stride);
   assign rsp_run_access_size = rsp_data.access_size;
   assign rsp_repeat_count = rsp_data.repeat_count;
   assign rsp_first_of_trace = rsp_data.first_of_trace;

endmodule
